// ===== src/ptc_pkg.sv =====
// Shared types and constants for the pressure/temperature compensation core.
// No dependencies.
`default_nettype none
package ptc_pkg;

   localparam int unsigned FINE_OFFSET = 128000;
   localparam int unsigned NP_BASE     = 1048576;
   localparam int unsigned DIV_SCALE   = 3125;
   localparam int unsigned DIV_STEPS   = 64;

   typedef enum logic [1:0] {
      CSR_TEMP_COEFFS  = 2'd0,
      CSR_PRESS_LOW    = 2'd1,
      CSR_PRESS_HIGH   = 2'd2,
      CSR_PRESS_NINE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } coeff_type;

   typedef struct packed {
      logic [31:0] fine;
      logic [31:0] temp;
      logic [19:0] raw_p;
   } temp_out_type;

   typedef struct packed {
      logic [63:0] num;
      logic [63:0] den;
      logic [31:0] temp;
   } div_in_type;

   typedef struct packed {
      logic [63:0] quot;
      logic [31:0] temp;
      logic        bad;
   } post_in_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] press;
      logic        invalid;
   } result_type;

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

endpackage
`default_nettype wire

// ===== src/ptc_temp.sv =====
// Temperature path: five stages producing fine temperature and centi-degrees.
// Depends on ptc_pkg.
`default_nettype none
module ptc_temp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire ptc_pkg::coeff_type    coeff,
   input  wire logic                  in_valid,
   input  wire logic [19:0]           raw_t,
   input  wire logic [19:0]           raw_p,
   output logic                       out_valid,
   output ptc_pkg::temp_out_type      out_data
);
   import ptc_pkg::*;

   logic [4:0]  vld_ff, vld_in;
   logic [31:0] d1_ff, d1_in, d2_ff, d2_in;
   logic [31:0] m1_ff, m1_in, m2_ff, m2_in;
   logic [31:0] tv1_ff, tv1_in, m3_ff, m3_in;
   logic [31:0] fine4_ff, fine4_in;
   logic [31:0] fine5_ff, fine5_in, temp_ff, temp_in;
   logic [19:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic [31:0] sq, f5;

   always_comb begin
      vld_in   = {vld_ff[3:0], in_valid};
      d1_in    = {15'b0, raw_t[19:3]} - {15'b0, coeff.t1, 1'b0};
      d2_in    = {16'b0, raw_t[19:4]} - {16'b0, coeff.t1};
      m1_in    = d1_ff * {{16{coeff.t2[15]}}, coeff.t2};
      m2_in    = d2_ff * d2_ff;
      tv1_in   = 32'($signed(m1_ff) >>> 11);
      sq       = 32'($signed(m2_ff) >>> 12);
      m3_in    = sq * {{16{coeff.t3[15]}}, coeff.t3};
      fine4_in = tv1_ff + 32'($signed(m3_ff) >>> 14);
      f5       = fine4_ff + {fine4_ff[29:0], 2'b0} + 32'd128;
      temp_in  = 32'($signed(f5) >>> 8);
      fine5_in = fine4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         p1_ff    <= raw_p;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         p2_ff    <= p1_ff;
         tv1_ff   <= tv1_in;
         m3_ff    <= m3_in;
         p3_ff    <= p2_ff;
         fine4_ff <= fine4_in;
         p4_ff    <= p3_ff;
         fine5_ff <= fine5_in;
         temp_ff  <= temp_in;
         p5_ff    <= p4_ff;
      end
   end

   assign out_valid      = vld_ff[4];
   assign out_data.fine  = fine5_ff;
   assign out_data.temp  = temp_ff;
   assign out_data.raw_p = p5_ff;
endmodule
`default_nettype wire

// ===== src/ptc_poly.sv =====
// Pressure polynomial: six stages building the 64-bit dividend and divisor.
// Depends on ptc_pkg.
`default_nettype none
module ptc_poly (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire ptc_pkg::coeff_type    coeff,
   input  wire logic                  in_valid,
   input  wire ptc_pkg::temp_out_type in_data,
   output logic                       out_valid,
   output ptc_pkg::div_in_type        out_data
);
   import ptc_pkg::*;

   logic [5:0]  vld_ff, vld_in;
   logic [33:0] v1_ff, v1_in;
   logic [20:0] np1_ff, np1_in, np2_ff, np3_ff, np4_ff;
   logic [63:0] vsq_ff, vsq_in, v1p5_ff, v1p5_in, v1p2_ff, v1p2_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, v1p5b_ff, v1p2b_ff;
   logic [63:0] v2_ff, v2_in, v1b_ff, v1b_in;
   logic [63:0] num0_ff, num0_in, x_ff, x_in;
   logic [63:0] num_ff, num_in, y_ff, y_in;
   logic [63:0] v1x;
   logic [31:0] t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;

   always_comb begin
      vld_in  = {vld_ff[4:0], in_valid};
      v1_in   = {{2{in_data.fine[31]}}, in_data.fine} - 34'(FINE_OFFSET);
      np1_in  = 21'(NP_BASE) - {1'b0, in_data.raw_p};
      v1x     = {{30{v1_ff[33]}}, v1_ff};
      vsq_in  = v1x * v1x;
      v1p5_in = v1x * sx16(coeff.p5);
      v1p2_in = v1x * sx16(coeff.p2);
      a_in    = vsq_ff * sx16(coeff.p6);
      b_in    = vsq_ff * sx16(coeff.p3);
      v2_in   = a_ff + {v1p5b_ff[46:0], 17'b0} + {{13{coeff.p4[15]}}, coeff.p4, 35'b0};
      v1b_in  = 64'($signed(b_ff) >>> 8) + {v1p2b_ff[51:0], 12'b0};
      num0_in = {12'b0, np4_ff, 31'b0} - v2_ff;
      x_in    = {16'h0000, 1'b1, 47'b0} + v1b_ff;
      num_in  = num0_ff * 64'(DIV_SCALE);
      y_in    = x_ff * {48'b0, coeff.p1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v1_ff    <= v1_in;
         np1_ff   <= np1_in;
         t1_ff    <= in_data.temp;
         vsq_ff   <= vsq_in;
         v1p5_ff  <= v1p5_in;
         v1p2_ff  <= v1p2_in;
         np2_ff   <= np1_ff;
         t2_ff    <= t1_ff;
         a_ff     <= a_in;
         b_ff     <= b_in;
         v1p5b_ff <= v1p5_ff;
         v1p2b_ff <= v1p2_ff;
         np3_ff   <= np2_ff;
         t3_ff    <= t2_ff;
         v2_ff    <= v2_in;
         v1b_ff   <= v1b_in;
         np4_ff   <= np3_ff;
         t4_ff    <= t3_ff;
         num0_ff  <= num0_in;
         x_ff     <= x_in;
         t5_ff    <= t4_ff;
         num_ff   <= num_in;
         y_ff     <= y_in;
         t6_ff    <= t5_ff;
      end
   end

   assign out_valid     = vld_ff[5];
   assign out_data.num  = num_ff;
   assign out_data.den  = 64'($signed(y_ff) >>> 33);
   assign out_data.temp = t6_ff;
endmodule
`default_nettype wire

// ===== src/ptc_div.sv =====
// Pipelined signed 64-bit divider, one restoring step per stage.
// Depends on ptc_pkg.
`default_nettype none
module ptc_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire ptc_pkg::div_in_type   in_data,
   output logic                       out_valid,
   output ptc_pkg::post_in_type       out_data
);
   import ptc_pkg::*;

   logic [DIV_STEPS:0] vld_ff;
   // remainder stays below the divisor magnitude, at most 2^63
   logic [62:0] rem_ff [0:DIV_STEPS-1];
   logic [63:0] dvd_ff [0:DIV_STEPS];
   logic [63:0] dsr_ff [0:DIV_STEPS-1];
   logic        neg_ff [0:DIV_STEPS];
   logic        bad_ff [0:DIV_STEPS];
   logic [31:0] tmp_ff [0:DIV_STEPS];
   logic [63:0] dvd_in [1:DIV_STEPS];
   logic        vfin_ff, bfin_ff;
   logic [63:0] qfin_ff, qfin_in;
   logic [31:0] tfin_ff;
   logic        na, nb;

   assign na = in_data.num[63];
   assign nb = in_data.den[63];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         vfin_ff <= 1'b0;
      end else if (advance) begin
         vld_ff  <= {vld_ff[DIV_STEPS-1:0], in_valid};
         vfin_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= '0;
         dvd_ff[0] <= na ? (~in_data.num + 64'd1) : in_data.num;
         dsr_ff[0] <= nb ? (~in_data.den + 64'd1) : in_data.den;
         neg_ff[0] <= na ^ nb;
         bad_ff[0] <= (in_data.den == 64'd0);
         tmp_ff[0] <= in_data.temp;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [63:0] rsh;
      logic        ge;
      always_comb begin
         rsh       = {rem_ff[k-1], dvd_ff[k-1][63]};
         ge        = (rsh >= dsr_ff[k-1]);
         dvd_in[k] = {dvd_ff[k-1][62:0], ge};
      end
      if (k < DIV_STEPS) begin : g_rem
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= ge ? 63'(rsh - dsr_ff[k-1]) : rsh[62:0];
               dsr_ff[k] <= dsr_ff[k-1];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            dvd_ff[k] <= dvd_in[k];
            neg_ff[k] <= neg_ff[k-1];
            bad_ff[k] <= bad_ff[k-1];
            tmp_ff[k] <= tmp_ff[k-1];
         end
      end
   end

   assign qfin_in = neg_ff[DIV_STEPS] ? (~dvd_ff[DIV_STEPS] + 64'd1) : dvd_ff[DIV_STEPS];

   always_ff @(posedge clock) begin
      if (advance) begin
         qfin_ff <= qfin_in;
         bfin_ff <= bad_ff[DIV_STEPS];
         tfin_ff <= tmp_ff[DIV_STEPS];
      end
   end

   assign out_valid     = vfin_ff;
   assign out_data.quot = qfin_ff;
   assign out_data.temp = tfin_ff;
   assign out_data.bad  = bfin_ff;
endmodule
`default_nettype wire

// ===== src/ptc_post.sv =====
// Post-division correction terms and final Q24.8 pressure, five stages.
// Depends on ptc_pkg.
`default_nettype none
module ptc_post (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire ptc_pkg::coeff_type    coeff,
   input  wire logic                  in_valid,
   input  wire ptc_pkg::post_in_type  in_data,
   output logic                       out_valid,
   output ptc_pkg::result_type        out_data
);
   import ptc_pkg::*;

   logic [4:0]  vld_ff;
   logic [63:0] q;
   logic [63:0] ll_ff, ll_in;
   logic [31:0] lh_ff, lh_in, hl_ff, hl_in;
   logic [63:0] pp8_ff, pp8_in, pp8b_ff, pp8c_ff;
   logic [63:0] qq_ff, qq_in, t9_ff, t9_in, sum_ff, sum_in;
   logic [63:0] res;
   logic [63:0] pa_ff, pb_ff, pc_ff;
   logic [31:0] ta_ff, tb_ff, tc_ff, td_ff, te_ff;
   logic        ba_ff, bb_ff, bc_ff, bd_ff, be_ff;
   logic [31:0] pr_ff;

   always_comb begin
      q      = 64'($signed(in_data.quot) >>> 13);
      ll_in  = {32'b0, q[31:0]} * {32'b0, q[31:0]};
      lh_in  = 32'(q[31:0] * q[63:32]);
      hl_in  = 32'(q[63:32] * q[31:0]);
      pp8_in = in_data.quot * sx16(coeff.p8);
      qq_in  = ll_ff + {lh_ff + hl_ff, 32'b0};
      t9_in  = qq_ff * sx16(coeff.p9);
      sum_in = pc_ff + 64'($signed(t9_ff) >>> 25) + 64'($signed(pp8c_ff) >>> 19);
      res    = 64'($signed(sum_ff) >>> 8) + {{44{coeff.p7[15]}}, coeff.p7, 4'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         pp8_ff  <= pp8_in;
         pa_ff   <= in_data.quot;
         ta_ff   <= in_data.temp;
         ba_ff   <= in_data.bad;
         qq_ff   <= qq_in;
         pp8b_ff <= pp8_ff;
         pb_ff   <= pa_ff;
         tb_ff   <= ta_ff;
         bb_ff   <= ba_ff;
         t9_ff   <= t9_in;
         pp8c_ff <= pp8b_ff;
         pc_ff   <= pb_ff;
         tc_ff   <= tb_ff;
         bc_ff   <= bb_ff;
         sum_ff  <= sum_in;
         td_ff   <= tc_ff;
         bd_ff   <= bc_ff;
         pr_ff   <= bd_ff ? 32'd0 : res[31:0];
         te_ff   <= td_ff;
         be_ff   <= bd_ff;
      end
   end

   assign out_valid        = vld_ff[4];
   assign out_data.temp    = te_ff;
   assign out_data.press   = pr_ff;
   assign out_data.invalid = be_ff;
endmodule
`default_nettype wire

// ===== src/pressure_temperature_compensation_core.sv =====
// Top level: calibration registers, compensation pipeline and output skid buffer.
// Depends on ptc_pkg, ptc_temp, ptc_poly, ptc_div, ptc_post.
//
//  channel | direction | payload
//  req_    | in        | tdata: raw_temperature, raw_pressure
//  rsp_    | out       | tdata: temperature_centi, pressure_q24_8; tuser: pressure_invalid
//  csr_    | in        | write enable, index, 64-bit data
//
// One beat per cycle sustained while the output buffer has room; data passes through
// the temperature, polynomial, divider, correction and output buffer stages in turn.
// The 64-step divider sets the depth. Synchronous reset clears valid bits.
// The whole pipeline holds when the two-entry output buffer is full.
`default_nettype none
module pressure_temperature_compensation_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // raw_temperature[19:0], raw_pressure[39:20]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // temperature_centi[31:0], pressure_q24_8[63:32]
   output logic             rsp_tuser,  // pressure_invalid
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import ptc_pkg::*;

   logic [47:0] tc_ff;
   logic [63:0] pl_ff, ph_ff;
   logic [15:0] p9_ff;
   coeff_type   coeff;

   logic         advance;
   logic         t_vld, p_vld, d_vld, o_vld;
   temp_out_type t_data;
   div_in_type   p_data;
   post_in_type  d_data;
   result_type   o_data;

   result_type  e0_ff, e0_in, e1_ff, e1_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= '0;
         pl_ff <= '0;
         ph_ff <= '0;
         p9_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP_COEFFS: tc_ff <= csr_wdata[47:0];
            CSR_PRESS_LOW:   pl_ff <= csr_wdata;
            CSR_PRESS_HIGH:  ph_ff <= csr_wdata;
            CSR_PRESS_NINE:  p9_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coeff.t1 = tc_ff[15:0];
      coeff.t2 = tc_ff[31:16];
      coeff.t3 = tc_ff[47:32];
      coeff.p1 = pl_ff[15:0];
      coeff.p2 = pl_ff[31:16];
      coeff.p3 = pl_ff[47:32];
      coeff.p4 = pl_ff[63:48];
      coeff.p5 = ph_ff[15:0];
      coeff.p6 = ph_ff[31:16];
      coeff.p7 = ph_ff[47:32];
      coeff.p8 = ph_ff[63:48];
      coeff.p9 = p9_ff;
   end

   assign advance    = (cnt_ff != 2'd2);
   assign req_tready = advance;

   ptc_temp u_temp (
      .clock, .reset, .advance, .coeff,
      .in_valid (req_tvalid),
      .raw_t    (req_tdata[19:0]),
      .raw_p    (req_tdata[39:20]),
      .out_valid(t_vld),
      .out_data (t_data)
   );

   ptc_poly u_poly (
      .clock, .reset, .advance, .coeff,
      .in_valid (t_vld),
      .in_data  (t_data),
      .out_valid(p_vld),
      .out_data (p_data)
   );

   ptc_div u_div (
      .clock, .reset, .advance,
      .in_valid (p_vld),
      .in_data  (p_data),
      .out_valid(d_vld),
      .out_data (d_data)
   );

   ptc_post u_post (
      .clock, .reset, .advance, .coeff,
      .in_valid (d_vld),
      .in_data  (d_data),
      .out_valid(o_vld),
      .out_data (o_data)
   );

   assign push = advance & o_vld;
   assign pop  = rsp_tvalid & rsp_tready;

   always_comb begin
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      cnt_in = cnt_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               e0_in  = o_data;
               cnt_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               e0_in = o_data;
            end else if (push) begin
               e1_in  = o_data;
               cnt_in = 2'd2;
            end else if (pop) begin
               cnt_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               e0_in  = e1_ff;
               cnt_in = 2'd1;
            end
         end
         default: cnt_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {e0_ff.press, e0_ff.temp};
   assign rsp_tuser  = e0_ff.invalid;
endmodule
`default_nettype wire
